### rtl/mrb_pkg.sv
package mrb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int STATE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 16;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	localparam logic [CFG_IW-1:0] CFG_DRY_MIX     = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_WET_MIX     = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SOUND_SCALE = 2'd2;

	localparam logic [CFG_DW-1:0] DRY_MIX_RST     = 16'd32768;
	localparam logic [CFG_DW-1:0] WET_MIX_RST     = 16'd32768;
	localparam logic [CFG_DW-1:0] SOUND_SCALE_RST = 16'd256;

	typedef struct packed {
		logic signed [COEF_W-1:0] cr;
		logic signed [COEF_W-1:0] ci;
		logic                     drive;
		logic                     pickup;
	} coef_t;

	typedef struct packed {
		logic signed [STATE_W-1:0] zr;
		logic signed [STATE_W-1:0] zi;
	} zstate_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_MIX4
	} state_t;

endpackage

### rtl/modal_resonator_bank_core.sv
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// in       | in_valid / in_ready | opcode, sample_in, mode_index, coef_real_in,
//          |                     | coef_imag_in, drive_enable, pickup_enable
// out      | out_valid/out_ready | sample_out, saturated
// cfg      | cfg_write           | cfg_index, cfg_data
//
// Load transaction: written to the coefficient memory on accept. Sample transaction:
// the sweep issues one complex multiply per mode per cycle through a 3-stage unit,
// then a 4-step mix sequencer forms the result.
// After reset a clearing pass zeroes the mode memories; in_ready low.
// A finished result waits in the output register; a new item is accepted meanwhile,
// and the next sample stalls only in its last mix step if the result is still held.
module modal_resonator_bank_core #(
	parameter int MODES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [mrb_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic        [mrb_pkg::INDEX_W-1:0]    mode_index,
	input  logic signed [mrb_pkg::COEF_W-1:0]     coef_real_in,
	input  logic signed [mrb_pkg::COEF_W-1:0]     coef_imag_in,
	input  logic                                  drive_enable,
	input  logic                                  pickup_enable,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mrb_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  saturated,
	input  logic                                  cfg_write,
	input  logic        [mrb_pkg::CFG_IW-1:0]     cfg_index,
	input  logic        [mrb_pkg::CFG_DW-1:0]     cfg_data
);
	import mrb_pkg::*;

	localparam int AW   = (MODES > 1) ? $clog2(MODES) : 1;
	localparam int SW   = STATE_W + $clog2(MODES);
	localparam int SHW  = SW - 21;
	localparam int PAW  = SW + 17;
	localparam int W1W  = SW + 2;
	localparam int SHB  = W1W - 22;
	localparam int PBW  = W1W + 17;
	localparam logic [AW-1:0] LAST = AW'(MODES - 1);
	localparam logic signed [PBW-1:0] OUT_MAX = PBW'(32767);
	localparam logic signed [PBW-1:0] OUT_MIN = PBW'(-32768);

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > 51'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -51'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	state_t state_q, state_d;
	logic clear_en, issue, out_load;

	logic [CFG_DW-1:0] dry_mix_q, wet_mix_q, sound_scale_q;

	coef_t   coef_mem  [MODES];
	zstate_t state_mem [MODES];

	logic [AW-1:0] clr_q, rd_addr_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SW-1:0] sum_q;

	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] a_s1, a_s2, a_s3;
	coef_t         coef_s1;
	zstate_t       st_s1;
	logic signed [49:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2;
	logic drive_s2, pickup_s2, drive_s3, pickup_s3;
	logic signed [31:0] re_s3, im_s3;

	logic signed [50:0] re_raw, im_raw, re_rnd, im_rnd, re_drv;
	logic signed [31:0] re_fin;
	zstate_t st_wr;

	logic          in_acc, load_we;
	logic [AW-1:0] ld_addr;
	coef_t         ld_entry;

	logic        [20:0]        sum_lo;
	logic signed [SHW-1:0]     sum_hi;
	logic signed [38:0]        pa_lo_q;
	logic signed [SHW+16:0]    pa_hi_q;
	logic signed [32:0]        dry_p_q;
	logic signed [PAW-1:0]     pa_full;
	logic signed [W1W-1:0]     w1_q;
	logic signed [17:0]        dry_r_q;
	logic        [21:0]        w1_lo;
	logic signed [SHB-1:0]     w1_hi;
	logic signed [39:0]        pb_lo_q;
	logic signed [SHB+16:0]    pb_hi_q;
	logic signed [PBW-1:0]     pb_full, wet_val, total;
	logic signed [SAMPLE_W-1:0] out_d, out_q;
	logic                       clip_d, clip_q, out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		clear_en = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clear_en = 1'b1;
				if (clr_q == LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && opcode == OP_SAMPLE) state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (rd_addr_q == LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) state_d = ST_MIX1;
			end
			ST_MIX1: state_d = ST_MIX2;
			ST_MIX2: state_d = ST_MIX3;
			ST_MIX3: state_d = ST_MIX4;
			ST_MIX4: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc   = in_valid && in_ready;
	assign load_we  = in_acc && opcode == OP_LOAD && 32'(mode_index) < 32'(MODES);
	assign ld_addr  = AW'(mode_index);
	assign ld_entry = '{cr: coef_real_in, ci: coef_imag_in,
	                    drive: drive_enable, pickup: pickup_enable};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_mix_q     <= DRY_MIX_RST;
			wet_mix_q     <= WET_MIX_RST;
			sound_scale_q <= SOUND_SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DRY_MIX:     dry_mix_q     <= cfg_data;
				CFG_WET_MIX:     wet_mix_q     <= cfg_data;
				CFG_SOUND_SCALE: sound_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counters and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			rd_addr_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear_en) clr_q <= clr_q + AW'(1);
			if (in_acc) begin
				rd_addr_q <= '0;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// mode memories
	always_ff @(posedge clk) begin
		if (clear_en) begin
			coef_mem[clr_q] <= '0;
		end else if (load_we) begin
			coef_mem[ld_addr] <= ld_entry;
		end
		if (clear_en) begin
			state_mem[clr_q] <= '0;
		end else if (v_s3) begin
			state_mem[a_s3] <= st_wr;
		end
		coef_s1 <= coef_mem[rd_addr_q];
		st_s1   <= state_mem[rd_addr_q];
	end

	// complex multiply unit
	assign re_raw = 51'(p_rr_s2) - 51'(p_ii_s2);
	assign im_raw = 51'(p_ir_s2) + 51'(p_ri_s2);
	assign re_rnd = (re_raw + 51'sd32768) >>> 16;
	assign im_rnd = (im_raw + 51'sd32768) >>> 16;
	assign re_drv = drive_s3 ? (51'(re_s3) + 51'(x_q)) : 51'(re_s3);
	assign re_fin = sat32(re_drv);
	assign st_wr  = '{zr: re_fin, zi: im_s3};

	always_ff @(posedge clk) begin
		a_s1      <= rd_addr_q;
		p_rr_s2   <= coef_s1.cr * st_s1.zr;
		p_ii_s2   <= coef_s1.ci * st_s1.zi;
		p_ir_s2   <= coef_s1.ci * st_s1.zr;
		p_ri_s2   <= coef_s1.cr * st_s1.zi;
		drive_s2  <= coef_s1.drive;
		pickup_s2 <= coef_s1.pickup;
		a_s2      <= a_s1;
		re_s3     <= sat32(re_rnd);
		im_s3     <= sat32(im_rnd);
		drive_s3  <= drive_s2;
		pickup_s3 <= pickup_s2;
		a_s3      <= a_s2;
		if (in_acc) begin
			x_q   <= sample_in;
			sum_q <= '0;
		end else if (v_s3 && pickup_s3) begin
			sum_q <= sum_q + SW'(re_fin);
		end
	end

	// mix: wet = round(round(sum * wet_mix / 2^15) * sound_scale / 2^8)
	assign sum_lo  = sum_q[20:0];
	assign sum_hi  = sum_q[SW-1:21];
	assign pa_full = (PAW'(pa_hi_q) <<< 21) + PAW'(pa_lo_q);
	assign w1_lo   = w1_q[21:0];
	assign w1_hi   = w1_q[W1W-1:22];
	assign pb_full = (PBW'(pb_hi_q) <<< 22) + PBW'(pb_lo_q);
	assign wet_val = (pb_full + PBW'(128)) >>> 8;
	assign total   = wet_val + PBW'(dry_r_q);

	always_comb begin
		clip_d = 1'b0;
		out_d  = SAMPLE_W'(total);
		if (total > OUT_MAX) begin
			out_d  = 16'sh7fff;
			clip_d = 1'b1;
		end else if (total < OUT_MIN) begin
			out_d  = 16'sh8000;
			clip_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MIX1) begin
			pa_lo_q <= $signed({1'b0, sum_lo}) * $signed({1'b0, wet_mix_q});
			pa_hi_q <= sum_hi * $signed({1'b0, wet_mix_q});
			dry_p_q <= x_q * $signed({1'b0, dry_mix_q});
		end
		if (state_q == ST_MIX2) begin
			w1_q    <= W1W'((pa_full + PAW'(16384)) >>> 15);
			dry_r_q <= 18'((dry_p_q + 33'sd16384) >>> 15);
		end
		if (state_q == ST_MIX3) begin
			pb_lo_q <= $signed({1'b0, w1_lo}) * $signed({1'b0, sound_scale_q});
			pb_hi_q <= w1_hi * $signed({1'b0, sound_scale_q});
		end
		if (out_load) begin
			out_q  <= out_d;
			clip_q <= clip_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign saturated  = clip_q;

`ifndef SYNTHESIS
	a_s3_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("mode pipeline active outside run");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == OP_SAMPLE) |=>
		(state_q == ST_RUN && rd_addr_q == '0 && sum_q == '0))
		else $error("sample transaction did not start a clean sweep");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX4 && (!out_valid_q || out_ready)) |=>
		(out_valid && state_q == ST_IDLE))
		else $error("finished result not presented");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!in_ready && !v_s1 && !out_valid_q))
		else $error("activity during clearing pass");
`endif

endmodule
